// ----- sv/sksi_pkg.sv -----
// sksi_pkg: shared types and constants for the sorted key set unit
// item structs, operation and status codes, controller state enum
// no dependencies
package sksi_pkg;

   localparam int CAPACITY_DEF  = 128;
   localparam int KEY_LIMIT_DEF = 1024;

   localparam int MODE_W  = 2;
   localparam int KEY_W   = 32;
   localparam int STAT_W  = 2;
   localparam int TAG_W   = 16;
   localparam int COUNT_W = 8;

   localparam logic [TAG_W-1:0] TAG_RESET = 16'd1;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]       mode;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic               found;
      logic [TAG_W-1:0]   class_out;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SEARCH_CMP,
      ST_CHECK,
      ST_SHIFT,
      ST_PLACE,
      ST_DONE
   } state_type;

endpackage

// ----- sv/sorted_key_set_insert_lookup_unit.sv -----
// Sorted key set with insert, lookup and clear. Keys in [0, KEY_LIMIT) are kept sorted and
// duplicate-free in a single-port-read, single-port-write memory of CAPACITY entries. One item
// is worked on at a time; the position search is a lower-bound binary search over the memory
// with a read state and a compare state per halving step. A new key on insert then moves every
// larger entry up one place through a read/write pipeline on the memory at one entry per cycle.
// Clear, unused codes and out-of-range keys go from idle straight to the done state. A finished
// result sits in an output register while the next item is taken. There is no clearing pass
// after reset. The user is to write class_tag through csr_ only while no item is in progress;
// the block itself does not enforce it.
// depends on sksi_pkg, sksi_ctrl, sksi_mem
module sorted_key_set_insert_lookup_unit #(
   parameter int CAPACITY  = sksi_pkg::CAPACITY_DEF,
   parameter int KEY_LIMIT = sksi_pkg::KEY_LIMIT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  sksi_pkg::req_type          req_item,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sksi_pkg::rsp_type          rsp_item,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [sksi_pkg::TAG_W-1:0] csr_data
);

   localparam int KEY_W  = $clog2(KEY_LIMIT);
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   logic [sksi_pkg::TAG_W-1:0] tag_ff, tag_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   sksi_pkg::rsp_type          rsp_item_ff, rsp_item_in;

   logic              res_valid;
   logic              res_taken;
   sksi_pkg::rsp_type res_item;

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [KEY_W-1:0]  mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [KEY_W-1:0]  mem_rd_data;

   sksi_ctrl #(
      .CAPACITY  (CAPACITY),
      .KEY_LIMIT (KEY_LIMIT),
      .KEY_W     (KEY_W),
      .ADDR_W    (ADDR_W),
      .CNT_W     (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_item    (req_item),
      .req_stall   (req_stall),
      .class_tag   (tag_ff),
      .res_valid   (res_valid),
      .res_item    (res_item),
      .res_taken   (res_taken),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   sksi_mem #(
      .DEPTH  (CAPACITY),
      .WIDTH  (KEY_W),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign csr_ready = 1'b1;
   assign tag_in    = (csr_valid && csr_ready) ? csr_data : tag_ff;

   assign res_taken = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      if (res_valid && res_taken) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff       <= sksi_pkg::TAG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- sv/sksi_mem.sv -----
// sksi_mem: key storage, one write port and one read port
// read data is registered and held while rd_en is low
// no dependencies
module sksi_mem #(
   parameter int DEPTH  = 128,
   parameter int WIDTH  = 10,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/sksi_ctrl.sv -----
// sksi_ctrl: sequencer for insert, lookup and clear over the key memory
// binary search, duplicate check, pipelined shift-up and entry count
// depends on sksi_pkg
module sksi_ctrl #(
   parameter int CAPACITY  = sksi_pkg::CAPACITY_DEF,
   parameter int KEY_LIMIT = sksi_pkg::KEY_LIMIT_DEF,
   parameter int KEY_W     = $clog2(KEY_LIMIT),
   parameter int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  sksi_pkg::req_type            req_item,
   output logic                         req_stall,
   input  logic [sksi_pkg::TAG_W-1:0]   class_tag,
   output logic                         res_valid,
   output sksi_pkg::rsp_type            res_item,
   input  logic                         res_taken,
   output logic                         mem_wr_en,
   output logic [ADDR_W-1:0]            mem_wr_addr,
   output logic [KEY_W-1:0]             mem_wr_data,
   output logic                         mem_rd_en,
   output logic [ADDR_W-1:0]            mem_rd_addr,
   input  logic [KEY_W-1:0]             mem_rd_data
);

   sksi_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [sksi_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [KEY_W-1:0]            key_ff, key_in;
   logic [CNT_W-1:0]            lo_ff, lo_in;
   logic [CNT_W-1:0]            hi_ff, hi_in;
   logic [CNT_W-1:0]            mid_ff, mid_in;
   logic [CNT_W-1:0]            idx_ff, idx_in;
   logic                        pend_ff, pend_in;
   logic [ADDR_W-1:0]           pend_addr_ff, pend_addr_in;
   logic [sksi_pkg::STAT_W-1:0] stat_ff, stat_in;
   logic                        found_ff, found_in;
   logic [sksi_pkg::TAG_W-1:0]  class_ff, class_in;

   logic             in_range;
   logic             decide;
   logic             hit;
   logic [CNT_W-1:0] mid;
   logic [CNT_W-1:0] idx_m1;

   assign in_range = !req_item.key[sksi_pkg::KEY_W-1]
                     && ($unsigned(req_item.key) < 32'(KEY_LIMIT));
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_m1   = idx_ff - CNT_W'(1);

   assign req_stall = (state_ff != sksi_pkg::ST_IDLE);

   assign res_item.status      = stat_ff;
   assign res_item.found       = found_ff;
   assign res_item.class_out   = class_ff;
   assign res_item.entry_count = sksi_pkg::COUNT_W'(cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sksi_pkg::ST_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      key_ff       <= key_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      stat_ff      <= stat_in;
      found_ff     <= found_in;
      class_ff     <= class_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      stat_in      = stat_ff;
      found_in     = found_ff;
      class_in     = class_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = pend_addr_ff;
      mem_wr_data  = mem_rd_data;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = mid[ADDR_W-1:0];
      res_valid    = 1'b0;
      decide       = 1'b0;
      hit          = 1'b0;

      case (state_ff)
         sksi_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_item.mode;
               key_in   = req_item.key[KEY_W-1:0];
               lo_in    = '0;
               hi_in    = cnt_ff;
               stat_in  = sksi_pkg::STATUS_OK;
               found_in = 1'b0;
               class_in = '0;
               state_in = sksi_pkg::ST_DONE;
               case (req_item.mode)
                  sksi_pkg::MODE_INSERT: begin
                     if (in_range) begin
                        state_in = sksi_pkg::ST_SEARCH;
                     end else begin
                        stat_in = sksi_pkg::STATUS_RANGE;
                     end
                  end
                  sksi_pkg::MODE_LOOKUP: begin
                     if (in_range) begin
                        state_in = sksi_pkg::ST_SEARCH;
                     end
                  end
                  sksi_pkg::MODE_CLEAR: begin
                     cnt_in = '0;
                  end
                  default: begin
                     state_in = sksi_pkg::ST_DONE;
                  end
               endcase
            end
         end
         sksi_pkg::ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mid[ADDR_W-1:0];
               mid_in      = mid;
               state_in    = sksi_pkg::ST_SEARCH_CMP;
            end else if (lo_ff < cnt_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = lo_ff[ADDR_W-1:0];
               state_in    = sksi_pkg::ST_CHECK;
            end else begin
               decide = 1'b1;
            end
         end
         sksi_pkg::ST_SEARCH_CMP: begin
            if (mem_rd_data < key_ff) begin
               lo_in = mid_ff + CNT_W'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = sksi_pkg::ST_SEARCH;
         end
         sksi_pkg::ST_CHECK: begin
            decide = 1'b1;
            hit    = (mem_rd_data == key_ff);
         end
         sksi_pkg::ST_SHIFT: begin
            // write back the entry read last cycle one place higher
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pend_addr_ff;
               mem_wr_data = mem_rd_data;
            end
            if (idx_ff > lo_ff) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = idx_m1[ADDR_W-1:0];
               pend_in      = 1'b1;
               pend_addr_in = idx_ff[ADDR_W-1:0];
               idx_in       = idx_m1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = sksi_pkg::ST_PLACE;
               end
            end
         end
         sksi_pkg::ST_PLACE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = lo_ff[ADDR_W-1:0];
            mem_wr_data = key_ff;
            cnt_in      = cnt_ff + CNT_W'(1);
            state_in    = sksi_pkg::ST_DONE;
         end
         sksi_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_taken) begin
               state_in = sksi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sksi_pkg::ST_IDLE;
         end
      endcase

      if (decide) begin
         state_in = sksi_pkg::ST_DONE;
         if (mode_ff == sksi_pkg::MODE_LOOKUP) begin
            found_in = hit;
            class_in = hit ? class_tag : '0;
         end else if (!hit) begin
            if (cnt_ff == CNT_W'(CAPACITY)) begin
               stat_in = sksi_pkg::STATUS_FULL;
            end else begin
               idx_in   = cnt_ff;
               pend_in  = 1'b0;
               state_in = sksi_pkg::ST_SHIFT;
            end
         end
      end
   end

endmodule

// ----- sv/sksi_checker.sv -----
// sksi_checker: port-level checks for the sorted key set unit, bound to the top level
// depends on sksi_pkg and sorted_key_set_insert_lookup_unit
module sksi_checker #(
   parameter int CAPACITY = sksi_pkg::CAPACITY_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sksi_pkg::rsp_type rsp_item
);

   // a held result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   // one item at a time: busy right after an accepted item
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while one is in progress");

   // class tag only on a hit, and a hit always reports ok
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.found |-> rsp_item.class_out == '0)
      else $error("class tag without a hit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.found |-> rsp_item.status == sksi_pkg::STATUS_OK)
      else $error("hit with non-ok status");

   // full is reported only with the table at capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == sksi_pkg::STATUS_FULL
      |-> rsp_item.entry_count == sksi_pkg::COUNT_W'(CAPACITY))
      else $error("full status below capacity");

endmodule

bind sorted_key_set_insert_lookup_unit sksi_checker #(
   .CAPACITY (CAPACITY)
) u_sksi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
